// ----- design/free_page_stack_allocator_unit_defines.svh -----
// Assertion macros for the free page stack allocator.
// Used by the top level; no other dependencies.
`ifndef FREE_PAGE_STACK_ALLOCATOR_UNIT_DEFINES_SVH
`define FREE_PAGE_STACK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FPSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/fpsa_pkg.sv -----
// Shared types and constants for the free page stack allocator.
// No dependencies; used by every module of the block.
package fpsa_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned FREE_BYTES_W = 28;
  localparam int unsigned STATUS_W     = 2;

  localparam int unsigned DEF_MAX_PAGES  = 32768;
  localparam int unsigned DEF_PAGE_SHIFT = 12;
  localparam int unsigned DEF_MAX_BATCH  = 64;

  localparam logic CMD_FREE  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

  localparam logic REG_LOW_LIMIT  = 1'b0;
  localparam logic REG_HIGH_LIMIT = 1'b1;

  localparam logic [DATA_W-1:0] LOW_LIMIT_RST  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] HIGH_LIMIT_RST = 32'h8800_0000;

  // Request to the shared add/subtract/compare unit.
  typedef struct packed {
    logic              sub;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic              lt;   // a < b, valid for subtract only
  } alu_rsp_t;

endpackage

// ----- design/fpsa_alu.sv -----
// Shared 32-bit add/subtract unit with unsigned less-than flag.
// Depends on fpsa_pkg.
module fpsa_alu (
  input  fpsa_pkg::alu_req_t req_i,
  output fpsa_pkg::alu_rsp_t rsp_o
);

  logic [fpsa_pkg::DATA_W:0] sum_wide;
  logic [fpsa_pkg::DATA_W-1:0] b_eff;

  assign b_eff    = req_i.sub ? ~req_i.b : req_i.b;
  assign sum_wide = {1'b0, req_i.a} + {1'b0, b_eff} + (fpsa_pkg::DATA_W+1)'(req_i.sub);

  assign rsp_o.sum = sum_wide[fpsa_pkg::DATA_W-1:0];
  // No carry out of a - b means a borrow, so a < b.
  assign rsp_o.lt  = req_i.sub & ~sum_wide[fpsa_pkg::DATA_W];

endmodule

// ----- design/fpsa_ram.sv -----
// Page number stack storage: one write port, one registered read port.
// Depends on fpsa_pkg for its parameter defaults.
module fpsa_ram #(
  parameter int unsigned DEPTH  = fpsa_pkg::DEF_MAX_PAGES,
  parameter int unsigned DATA_W = fpsa_pkg::DATA_W - fpsa_pkg::DEF_PAGE_SHIFT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/fpsa_ctrl.sv -----
// Sequencer of the allocator: runs free and allocate commands through the
// shared ALU and the stack RAM, and holds the result register. Uses fpsa_pkg.
module fpsa_ctrl #(
  parameter int unsigned MAX_PAGES  = fpsa_pkg::DEF_MAX_PAGES,
  parameter int unsigned PAGE_SHIFT = fpsa_pkg::DEF_PAGE_SHIFT,
  parameter int unsigned MAX_BATCH  = fpsa_pkg::DEF_MAX_BATCH,
  localparam int unsigned CNT_W     = $clog2(MAX_PAGES + 1),
  localparam int unsigned IDX_W     = $clog2(MAX_PAGES),
  localparam int unsigned PAGE_W    = fpsa_pkg::DATA_W - PAGE_SHIFT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [fpsa_pkg::DATA_W-1:0]       low_limit_i,
  input  logic [fpsa_pkg::DATA_W-1:0]       high_limit_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic [fpsa_pkg::DATA_W-1:0]       address_i,
  input  logic [fpsa_pkg::COUNT_W-1:0]      count_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fpsa_pkg::DATA_W-1:0]       page_address_o,
  output logic                              granted_o,
  output logic [fpsa_pkg::COUNT_W-1:0]      granted_count_o,
  output logic [fpsa_pkg::FREE_BYTES_W-1:0] free_bytes_o,
  output logic [fpsa_pkg::STATUS_W-1:0]     status_o,
  output logic                              last_o,
  output fpsa_pkg::alu_req_t                alu_req_o,
  input  fpsa_pkg::alu_rsp_t                alu_rsp_i,
  output logic                              ram_we_o,
  output logic [IDX_W-1:0]                  ram_waddr_o,
  output logic [PAGE_W-1:0]                 ram_wdata_o,
  output logic                              ram_re_o,
  output logic [IDX_W-1:0]                  ram_raddr_o,
  input  logic [PAGE_W-1:0]                 ram_rdata_i
);

  localparam int unsigned FB_WIDE_W = fpsa_pkg::DATA_W + PAGE_SHIFT;
  localparam logic [fpsa_pkg::COUNT_W-1:0] BATCH_MAX = fpsa_pkg::COUNT_W'(MAX_BATCH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PAGES);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_F_LO   = 4'd1;
  localparam logic [3:0] S_F_HI   = 4'd2;
  localparam logic [3:0] S_F_PUSH = 4'd3;
  localparam logic [3:0] S_A_MIN  = 4'd4;
  localparam logic [3:0] S_A_LEFT = 4'd5;
  localparam logic [3:0] S_POP    = 4'd6;
  localparam logic [3:0] S_POPW   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]                   state_q, state_d;
  logic [CNT_W-1:0]             free_cnt_q, free_cnt_d;
  logic                         bad_q, bad_d;
  logic [fpsa_pkg::COUNT_W-1:0] want_q, want_d;
  logic [fpsa_pkg::COUNT_W-1:0] grant_n_q, grant_n_d;
  logic [fpsa_pkg::COUNT_W-1:0] gcnt_q, gcnt_d;
  logic [fpsa_pkg::DATA_W-1:0]  addr_q, addr_d;

  logic [fpsa_pkg::DATA_W-1:0]       page_q, page_d;
  logic                              granted_q, granted_d;
  logic [fpsa_pkg::COUNT_W-1:0]      ocnt_q, ocnt_d;
  logic [fpsa_pkg::FREE_BYTES_W-1:0] fb_q, fb_d;
  logic [fpsa_pkg::STATUS_W-1:0]     status_q, status_d;
  logic                              last_q, last_d;

  logic [fpsa_pkg::COUNT_W-1:0] count_one;
  logic [fpsa_pkg::COUNT_W-1:0] count_sat;
  logic [FB_WIDE_W-1:0]         fb_cnt_wide, fb_alu_wide;
  logic                         misaligned;

  assign count_one  = (count_i == '0) ? fpsa_pkg::COUNT_W'(1) : count_i;
  assign count_sat  = (count_one > BATCH_MAX) ? BATCH_MAX : count_one;
  assign misaligned = addr_q[PAGE_SHIFT-1:0] != '0;

  // Free bytes from the current count and from the ALU result.
  assign fb_cnt_wide = FB_WIDE_W'(free_cnt_q) << PAGE_SHIFT;
  assign fb_alu_wide = FB_WIDE_W'(alu_rsp_i.sum) << PAGE_SHIFT;

  always_comb begin
    state_d    = state_q;
    free_cnt_d = free_cnt_q;
    bad_d      = bad_q;
    want_d     = want_q;
    grant_n_d  = grant_n_q;
    gcnt_d     = gcnt_q;
    addr_d     = addr_q;
    page_d     = page_q;
    granted_d  = granted_q;
    ocnt_d     = ocnt_q;
    fb_d       = fb_q;
    status_d   = status_q;
    last_d     = last_q;

    alu_req_o.sub = 1'b1;
    alu_req_o.a   = fpsa_pkg::DATA_W'(free_cnt_q);
    alu_req_o.b   = fpsa_pkg::DATA_W'(1);

    ram_we_o    = 1'b0;
    ram_waddr_o = free_cnt_q[IDX_W-1:0];
    ram_wdata_o = addr_q[fpsa_pkg::DATA_W-1:PAGE_SHIFT];
    ram_re_o    = 1'b0;
    ram_raddr_o = alu_rsp_i.sum[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          addr_d  = address_i;
          want_d  = count_sat;
          gcnt_d  = '0;
          state_d = (command_i == fpsa_pkg::CMD_FREE) ? S_F_LO : S_A_MIN;
        end
      end
      S_F_LO: begin
        alu_req_o.a = addr_q;
        alu_req_o.b = low_limit_i;
        bad_d       = misaligned | alu_rsp_i.lt;
        state_d     = S_F_HI;
      end
      S_F_HI: begin
        alu_req_o.a = addr_q;
        alu_req_o.b = high_limit_i;
        page_d      = '0;
        granted_d   = 1'b0;
        ocnt_d      = '0;
        last_d      = 1'b1;
        fb_d        = fb_cnt_wide[fpsa_pkg::FREE_BYTES_W-1:0];
        if (bad_q || !alu_rsp_i.lt) begin
          status_d = fpsa_pkg::STATUS_BAD_ADDR;
          state_d  = S_OUT;
        end else if (free_cnt_q == CNT_FULL) begin
          status_d = fpsa_pkg::STATUS_FULL;
          state_d  = S_OUT;
        end else begin
          state_d = S_F_PUSH;
        end
      end
      S_F_PUSH: begin
        alu_req_o.sub = 1'b0;
        ram_we_o      = 1'b1;
        free_cnt_d    = alu_rsp_i.sum[CNT_W-1:0];
        fb_d          = fb_alu_wide[fpsa_pkg::FREE_BYTES_W-1:0];
        status_d      = fpsa_pkg::STATUS_OK;
        state_d       = S_OUT;
      end
      S_A_MIN: begin
        // Grant the smaller of the wanted count and the pool size.
        alu_req_o.b = fpsa_pkg::DATA_W'(want_q);
        grant_n_d   = alu_rsp_i.lt ? fpsa_pkg::COUNT_W'(free_cnt_q) : want_q;
        state_d     = S_A_LEFT;
      end
      S_A_LEFT: begin
        alu_req_o.b = fpsa_pkg::DATA_W'(grant_n_q);
        fb_d        = fb_alu_wide[fpsa_pkg::FREE_BYTES_W-1:0];
        status_d    = fpsa_pkg::STATUS_OK;
        if (grant_n_q == '0) begin
          page_d    = '0;
          granted_d = 1'b0;
          ocnt_d    = '0;
          last_d    = 1'b1;
          state_d   = S_OUT;
        end else begin
          state_d = S_POP;
        end
      end
      S_POP: begin
        ram_re_o   = 1'b1;
        free_cnt_d = alu_rsp_i.sum[CNT_W-1:0];
        gcnt_d     = gcnt_q + fpsa_pkg::COUNT_W'(1);
        state_d    = S_POPW;
      end
      S_POPW: begin
        page_d    = {ram_rdata_i, {PAGE_SHIFT{1'b0}}};
        granted_d = 1'b1;
        ocnt_d    = gcnt_q;
        last_d    = gcnt_q == grant_n_q;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = last_q ? S_IDLE : S_POP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      free_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      free_cnt_q <= free_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bad_q     <= bad_d;
    want_q    <= want_d;
    grant_n_q <= grant_n_d;
    gcnt_q    <= gcnt_d;
    addr_q    <= addr_d;
    page_q    <= page_d;
    granted_q <= granted_d;
    ocnt_q    <= ocnt_d;
    fb_q      <= fb_d;
    status_q  <= status_d;
    last_q    <= last_d;
  end

  assign in_ready_o      = state_q == S_IDLE;
  assign out_valid_o     = state_q == S_OUT;
  assign page_address_o  = page_q;
  assign granted_o       = granted_q;
  assign granted_count_o = ocnt_q;
  assign free_bytes_o    = fb_q;
  assign status_o        = status_q;
  assign last_o          = last_q;

endmodule

// ----- design/free_page_stack_allocator_unit.sv -----
// Top level of the free page stack allocator: limit registers, sequencer,
// shared ALU and stack RAM. Uses fpsa_pkg, fpsa_alu, fpsa_ram, fpsa_ctrl.
//
// A LIFO pool of free physical pages. A free transaction (command 0) checks
// that the address is page aligned and inside [low_limit, high_limit), then
// pushes its page number and returns one result (status 1 on a bad address,
// status 2 when the stack already holds MAX_PAGES pages). An allocate
// transaction (command 1) pops min(count, pages free) pages, count 0 meaning
// one and count capped at MAX_BATCH, and returns one result per page with
// last set on the final one; an empty pool gives one result with granted 0.
// free_bytes on every result is the pool size after the whole transaction.
// Timing: one shared 32-bit add/subtract/compare unit does both limit checks,
// the batch size, the remaining count and every push/pop pointer step, one
// operation per cycle. A free checks the low, then the high limit and pushes
// unless rejected; an allocate finds the batch size and the count left, then
// per page steps the pointer, reads the RAM and registers the result.
// Input is taken only when no transaction is in flight. The stack RAM has no
// reset and needs no clearing pass: only entries below the count are read.
// The user writes low_limit and high_limit via the cfg port only while idle; not enforced.
`include "free_page_stack_allocator_unit_defines.svh"

module free_page_stack_allocator_unit #(
  parameter int unsigned MAX_PAGES  = fpsa_pkg::DEF_MAX_PAGES,
  parameter int unsigned PAGE_SHIFT = fpsa_pkg::DEF_PAGE_SHIFT,
  parameter int unsigned MAX_BATCH  = fpsa_pkg::DEF_MAX_BATCH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [fpsa_pkg::DATA_W-1:0]       cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic [fpsa_pkg::DATA_W-1:0]       address_i,
  input  logic [fpsa_pkg::COUNT_W-1:0]      count_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fpsa_pkg::DATA_W-1:0]       page_address_o,
  output logic                              granted_o,
  output logic [fpsa_pkg::COUNT_W-1:0]      granted_count_o,
  output logic [fpsa_pkg::FREE_BYTES_W-1:0] free_bytes_o,
  output logic [fpsa_pkg::STATUS_W-1:0]     status_o,
  output logic                              last_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_PAGES);
  localparam int unsigned PAGE_W = fpsa_pkg::DATA_W - PAGE_SHIFT;

  logic [fpsa_pkg::DATA_W-1:0] low_limit_q, high_limit_q;

  fpsa_pkg::alu_req_t alu_req;
  fpsa_pkg::alu_rsp_t alu_rsp;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [PAGE_W-1:0] ram_wdata, ram_rdata;

  // Limit registers: hold until written; the user writes them only while idle (not enforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q  <= fpsa_pkg::LOW_LIMIT_RST;
      high_limit_q <= fpsa_pkg::HIGH_LIMIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == fpsa_pkg::REG_LOW_LIMIT) begin
        low_limit_q <= cfg_data_i;
      end else begin
        high_limit_q <= cfg_data_i;
      end
    end
  end

  fpsa_ctrl #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .MAX_BATCH  (MAX_BATCH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .low_limit_i     (low_limit_q),
    .high_limit_i    (high_limit_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .address_i       (address_i),
    .count_i         (count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .page_address_o  (page_address_o),
    .granted_o       (granted_o),
    .granted_count_o (granted_count_o),
    .free_bytes_o    (free_bytes_o),
    .status_o        (status_o),
    .last_o          (last_o),
    .alu_req_o       (alu_req),
    .alu_rsp_i       (alu_rsp),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata)
  );

  fpsa_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  fpsa_ram #(
    .DEPTH  (MAX_PAGES),
    .DATA_W (PAGE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // One transaction in flight: never take input while a result is pending.
  `FPSA_ASSERT_NOW(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o, "input ready while result pending")
  // A granted page is always a successful allocate result.
  `FPSA_ASSERT_NOW(a_grant_ok, clk_i, rst_ni, out_valid_o && granted_o, (status_o == fpsa_pkg::STATUS_OK) && (granted_count_o != '0), "granted result with bad status or zero count")
  // An accepted transaction keeps the block busy in the next cycle.
  `FPSA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready right after accepting input")

endmodule

// ----- test/fpsa_tb_pkg.sv -----
`timescale 1ns / 1ps
// Result record and scoreboard for the free page stack allocator testbench.
// Depends on fpsa_pkg for widths, commands, status codes and register indexes.
package fpsa_tb_pkg;
  import fpsa_pkg::*;

  localparam int unsigned PAGE_SHIFT = DEF_PAGE_SHIFT;
  localparam int unsigned MAX_PAGES  = DEF_MAX_PAGES;
  localparam int unsigned MAX_BATCH  = DEF_MAX_BATCH;
  localparam int unsigned PAGE_NUM_W = DATA_W - PAGE_SHIFT;

  typedef struct packed {
    logic [DATA_W-1:0]       page_address;
    logic                    granted;
    logic [COUNT_W-1:0]      granted_count;
    logic [FREE_BYTES_W-1:0] free_bytes;
    logic [STATUS_W-1:0]     status;
    logic                    last;
  } pool_result_t;

  class pool_scoreboard;
    logic [DATA_W-1:0]     low_limit;
    logic [DATA_W-1:0]     high_limit;
    logic [PAGE_NUM_W-1:0] pages [MAX_PAGES];
    int unsigned           pool_depth;
    pool_result_t          awaited_results [$];
    int unsigned mismatches, checked, peak_depth;
    int unsigned frees, bad_frees, full_frees, allocs, empty_allocs, pages_granted;

    function new();
      low_limit  = LOW_LIMIT_RST;
      high_limit = HIGH_LIMIT_RST;
      pool_depth = 0;
    endfunction

    function void set_limit(logic idx, logic [DATA_W-1:0] value);
      if (idx == REG_LOW_LIMIT) low_limit = value;
      else high_limit = value;
    endfunction

    function logic [FREE_BYTES_W-1:0] bytes_for(int unsigned depth);
      return FREE_BYTES_W'(depth << PAGE_SHIFT);
    endfunction

    // Apply one accepted transaction to the pool and queue the results it must produce.
    function void predict_pool_results(logic cmd, logic [DATA_W-1:0] addr,
                                       logic [COUNT_W-1:0] cnt);
      pool_result_t r;
      int unsigned  want;
      int unsigned  grant;
      r = '0;
      if (cmd == CMD_FREE) begin
        frees++;
        // address check wins over the full check
        if (addr[PAGE_SHIFT-1:0] != '0 || addr < low_limit || addr >= high_limit) begin
          r.status = STATUS_BAD_ADDR;
          bad_frees++;
        end else if (pool_depth == MAX_PAGES) begin
          r.status = STATUS_FULL;
          full_frees++;
        end else begin
          pages[pool_depth] = addr[DATA_W-1:PAGE_SHIFT];
          pool_depth++;
          if (pool_depth > peak_depth) peak_depth = pool_depth;
        end
        r.free_bytes = bytes_for(pool_depth);
        r.last       = 1'b1;
        awaited_results.push_back(r);
        return;
      end
      allocs++;
      want = (cnt == 0) ? 1 : cnt;
      if (want > MAX_BATCH) want = MAX_BATCH;
      grant = (want < pool_depth) ? want : pool_depth;
      // every result of the batch carries the pool size after the whole transaction
      r.free_bytes = bytes_for(pool_depth - grant);
      if (grant == 0) begin
        empty_allocs++;
        r.last = 1'b1;
        awaited_results.push_back(r);
        return;
      end
      for (int unsigned n = 1; n <= grant; n++) begin
        r.page_address  = {pages[pool_depth - n], {PAGE_SHIFT{1'b0}}};
        r.granted       = 1'b1;
        r.granted_count = COUNT_W'(n);
        r.last          = (n == grant);
        awaited_results.push_back(r);
      end
      pool_depth    -= grant;
      pages_granted += grant;
    endfunction

    function string show(pool_result_t r);
      return $sformatf("page %h granted %0d count %0d free_bytes %0d status %0d last %0d",
                       r.page_address, r.granted, r.granted_count, r.free_bytes,
                       r.status, r.last);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("tb: %s", msg);
    endfunction

    function void compare_result(pool_result_t got);
      pool_result_t want;
      checked++;
      if (awaited_results.size() == 0) begin
        flag($sformatf("result with nothing pending: %s", show(got)));
        return;
      end
      want = awaited_results.pop_front();
      if (got.page_address !== want.page_address || got.granted !== want.granted ||
          got.granted_count !== want.granted_count || got.free_bytes !== want.free_bytes ||
          got.status !== want.status || got.last !== want.last)
        flag($sformatf("result %0d mismatch\n  expected %s\n  actual   %s",
                       checked, show(want), show(got)));
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction
  endclass

endpackage

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for free_page_stack_allocator_unit.
// Depends on fpsa_pkg and fpsa_tb_pkg (scoreboard); drives the block by plain tasks.
module tb;
  import fpsa_pkg::*;
  import fpsa_tb_pkg::*;

  localparam longint unsigned   PAGE_BYTES  = 64'd1 << PAGE_SHIFT;
  localparam logic [DATA_W-1:0] PAGE_MASK   = DATA_W'(PAGE_BYTES - 1);
  localparam int unsigned       STALL_MAX   = 6;
  localparam int unsigned       CYCLE_LIMIT = 4_000_000;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic                    cfg_index_i = 1'b0;
  logic [DATA_W-1:0]       cfg_data_i  = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic                    command_i   = CMD_FREE;
  logic [DATA_W-1:0]       address_i   = '0;
  logic [COUNT_W-1:0]      count_i     = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [DATA_W-1:0]       page_address_o;
  logic                    granted_o;
  logic [COUNT_W-1:0]      granted_count_o;
  logic [FREE_BYTES_W-1:0] free_bytes_o;
  logic [STATUS_W-1:0]     status_o;
  logic                    last_o;

  pool_scoreboard sb;
  pool_result_t   seen_result;
  int unsigned    burst_left;
  int unsigned    gap_max;
  int unsigned    stall_pct;
  int unsigned    stall_left;
  int unsigned    limit_settings;
  int unsigned    cycles;

  free_page_stack_allocator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .address_i       (address_i),
    .count_i         (count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .page_address_o  (page_address_o),
    .granted_o       (granted_o),
    .granted_count_o (granted_count_o),
    .free_bytes_o    (free_bytes_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or drops a handshake.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: check every accepted result, then pick the next ready value.
  // Signals read here hold their pre-edge values, so the handshake is race free.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        seen_result = '{page_address_o, granted_o, granted_count_o, free_bytes_o,
                        status_o, last_o};
        sb.compare_result(seen_result);
      end
      // stall in runs of random length; stall_pct 0 gives a stretch at full rate
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, STALL_MAX - 1);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Present one transaction and hold it until accepted. Bursts of random length
  // are separated by random gaps; gap_max 0 keeps valid high back to back.
  task automatic send_item(logic cmd, logic [DATA_W-1:0] addr, logic [COUNT_W-1:0] cnt);
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    address_i  <= addr;
    count_i    <= cnt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.predict_pool_results(cmd, addr, cnt);
    burst_left--;
  endtask

  // Drop valid and hold off until every predicted result has been taken.
  task automatic wait_pool_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write both limit registers on back-to-back cycles; only called while idle.
  task automatic set_limits(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_LOW_LIMIT;
    cfg_data_i  <= lo;
    @(posedge clk_i);
    cfg_index_i <= REG_HIGH_LIMIT;
    cfg_data_i  <= hi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_limit(REG_LOW_LIMIT, lo);
    sb.set_limit(REG_HIGH_LIMIT, hi);
    limit_settings++;
  endtask

  // Aligned page inside the current window, biased toward its two ends.
  function automatic logic [DATA_W-1:0] pick_page_address(output bit found);
    longint unsigned first_pg;
    longint unsigned end_pg;
    longint unsigned pg;
    first_pg = ({32'b0, sb.low_limit} + PAGE_BYTES - 1) >> PAGE_SHIFT;
    end_pg   = ({32'b0, sb.high_limit} + PAGE_BYTES - 1) >> PAGE_SHIFT;
    found    = end_pg > first_pg;
    if (!found) return $urandom;
    case ($urandom_range(0, 4))
      0: pg = first_pg;
      1: pg = end_pg - 1;
      default: pg = first_pg + $urandom_range(0, 32'(end_pg - first_pg - 1));
    endcase
    return DATA_W'(pg << PAGE_SHIFT);
  endfunction

  // Mostly rejected addresses: random, unaligned, just below low, at or above high.
  function automatic logic [DATA_W-1:0] pick_bad_address();
    bit                found;
    logic [DATA_W-1:0] a;
    a = pick_page_address(found);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return a | DATA_W'($urandom_range(1, PAGE_MASK));
      2: return (sb.low_limit & ~PAGE_MASK) - DATA_W'(PAGE_BYTES);
      default: return (sb.high_limit + PAGE_MASK) & ~PAGE_MASK;
    endcase
  endfunction

  // Mostly single pages, now and then a long batch.
  function automatic logic [COUNT_W-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return COUNT_W'($urandom_range(0, 2));
    if (roll < 97) return COUNT_W'($urandom_range(3, 16));
    return COUNT_W'($urandom_range(17, MAX_BATCH));
  endfunction

  // One limit setting: mostly good frees and allocates, the rest rejected frees.
  task automatic random_phase(int unsigned items, logic [DATA_W-1:0] lo,
                              logic [DATA_W-1:0] hi, int unsigned gaps,
                              int unsigned stall);
    int unsigned       roll;
    bit                found;
    logic [DATA_W-1:0] a;
    wait_pool_idle();
    set_limits(lo, hi);
    gap_max   = gaps;
    stall_pct = stall;
    repeat (items) begin
      roll = $urandom_range(0, 99);
      a    = pick_page_address(found);
      if (roll < 60 && found)
        send_item(CMD_FREE, a, COUNT_W'($urandom_range(0, MAX_BATCH)));
      else if (roll < 85)
        send_item(CMD_ALLOC, $urandom, pick_count());
      else
        send_item(CMD_FREE, pick_bad_address(), COUNT_W'($urandom_range(0, MAX_BATCH)));
      // now and then let the pool run completely dry of results
      if ($urandom_range(0, 39) == 0) wait_pool_idle();
    end
  endtask

  initial begin
    int unsigned       lo_pg;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;

    sb        = new();
    gap_max   = 3;
    stall_pct = 25;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset limits first: empty pool, window edges, misalignment,
    // count zero, a batch that runs the pool dry.
    send_item(CMD_ALLOC, '0, 7'd0);
    send_item(CMD_FREE, 32'h8000_0000, 7'd0);
    send_item(CMD_FREE, 32'h87FF_F000, 7'd0);
    send_item(CMD_FREE, 32'h8800_0000, 7'd0);
    send_item(CMD_FREE, 32'h7FFF_F000, 7'd0);
    send_item(CMD_FREE, 32'h8000_0001, 7'd0);
    send_item(CMD_FREE, 32'h8000_0800, 7'd0);
    send_item(CMD_ALLOC, '0, 7'd0);
    send_item(CMD_ALLOC, '1, 7'd64);
    send_item(CMD_ALLOC, '0, 7'd1);

    // widest window: lowest and highest page both legal
    wait_pool_idle();
    set_limits('0, '1);
    send_item(CMD_FREE, 32'h0000_0000, 7'd64);
    send_item(CMD_FREE, 32'hFFFF_F000, 7'd0);
    send_item(CMD_FREE, 32'hFFFF_FFFF, 7'd0);
    send_item(CMD_FREE, 32'h0000_0FFF, 7'd0);
    send_item(CMD_ALLOC, '0, 7'd3);

    // empty window, then limits in the wrong order: every free is rejected
    wait_pool_idle();
    set_limits(32'h1000_0000, 32'h1000_0000);
    send_item(CMD_FREE, 32'h1000_0000, 7'd0);
    wait_pool_idle();
    set_limits(32'hFFFF_F000, '0);
    send_item(CMD_FREE, 32'hFFFF_F000, 7'd0);
    send_item(CMD_FREE, 32'h0000_0000, 7'd0);
    send_item(CMD_ALLOC, '0, 7'd2);

    // Random part over several windows, with and without idling on each side.
    random_phase(100, '0, '1, 8, 30);
    random_phase(80, LOW_LIMIT_RST, HIGH_LIMIT_RST, 0, 0);
    // narrow window with unaligned edges somewhere in the address space
    lo_pg = $urandom_range(1, (1 << (DATA_W - PAGE_SHIFT)) - 80);
    lo    = DATA_W'(lo_pg << PAGE_SHIFT) - DATA_W'($urandom_range(0, PAGE_MASK));
    hi    = DATA_W'((lo_pg + $urandom_range(1, 64)) << PAGE_SHIFT)
            + DATA_W'($urandom_range(0, PAGE_MASK));
    random_phase(80, lo, hi, 4, 60);
    // inverted or equal limits
    hi = $urandom_range(0, 32'hF000_0000);
    random_phase(30, hi + DATA_W'($urandom_range(0, 65536)), hi, 8, 20);
    random_phase(70, 32'h0000_1000, 32'hFFFF_F000, 6, 40);

    // Let everything drain, then watch a while for stray results.
    wait_pool_idle();
    repeat (50) @(posedge clk_i);

    $display("tb: %0d frees (%0d bad address, %0d pool full), %0d allocates (%0d empty), %0d pages granted",
             sb.frees, sb.bad_frees, sb.full_frees, sb.allocs, sb.empty_allocs,
             sb.pages_granted);
    $display("tb: %0d results compared under %0d limit settings, pool peaked at %0d of %0d pages",
             sb.checked, limit_settings, sb.peak_depth, MAX_PAGES);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", sb.mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
